// File: rtl/core/ptb_pkg.sv
package ptb_pkg;

    localparam int PERIOD_W = 16;
    localparam int INDEX_W  = 4;
    localparam int ACTION_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 3'd0,
        ACT_CONFIGURE = 3'd1,
        ACT_ENABLE    = 3'd2,
        ACT_DISABLE   = 3'd3,
        ACT_TAKE      = 3'd4,
        ACT_RESET_ONE = 3'd5,
        ACT_READ_EN   = 3'd6
    } t_action;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  timer_index;
        logic [PERIOD_W-1:0] period_ms;
    } t_in_item;

    typedef struct packed {
        logic status;
        logic ready_out;
        logic enabled_out;
    } t_out_item;

    typedef struct packed {
        logic                fire;
        logic [PERIOD_W-1:0] count;
    } t_upd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_POST
    } t_state;

endpackage

// File: rtl/core/ptb_mem.sv
module ptb_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int WIDTH  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/ptb_update.sv
module ptb_update (
    input  logic [ptb_pkg::PERIOD_W-1:0] i_count,
    input  logic [ptb_pkg::PERIOD_W-1:0] i_period,
    output ptb_pkg::t_upd                o_upd
);
    import ptb_pkg::*;

    logic [PERIOD_W:0] next_count;

    // widened so the restart compare can never wrap
    assign next_count  = {1'b0, i_count} + (PERIOD_W+1)'(1);
    assign o_upd.fire  = next_count >= {1'b0, i_period};
    assign o_upd.count = o_upd.fire ? '0 : next_count[PERIOD_W-1:0];

endmodule

// File: rtl/core/periodic_timer_bank.sv
// Channel | direction | handshake              | payload
// in      | receive   | i_in_valid / o_in_stall | i_in_item  (t_in_item)
// out     | send      | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// Non-tick items are accepted, then their result is loaded in S_POST once the output is free.
// A tick runs a read-modify-write sweep over the period and count memories,
// one timer per cycle, before its result is loaded in S_POST.
// Reset clears every timer at once; no clearing pass is needed.
// A stalled output holds the block in its result state until it drains.
module periodic_timer_bank #(
    parameter int TIMER_COUNT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ptb_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ptb_pkg::t_out_item o_out_item
);
    import ptb_pkg::*;

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W = $clog2(TIMER_COUNT + 1);
    localparam logic [INDEX_W:0] LIMIT = (INDEX_W+1)'(TIMER_COUNT);

    t_state r_state, n_state;
    t_in_item r_item;
    t_out_item r_out_item, n_out_item;
    logic r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_rd_ptr;
    logic r_wb_vld;
    logic [IDX_W-1:0] r_wb_ptr;
    logic [TIMER_COUNT-1:0] r_enable, n_enable;
    logic [TIMER_COUNT-1:0] r_ready, n_ready;

    logic in_range, out_free, rd_en, accept;
    logic [IDX_W-1:0] addr;
    logic per_wr_en, cnt_wr_en;
    logic [PERIOD_W-1:0] per_wr_data, cnt_wr_data;
    logic [IDX_W-1:0] cnt_wr_addr;
    logic [PERIOD_W-1:0] per_rd_data, cnt_rd_data;
    t_upd upd;

    assign in_range = {1'b0, r_item.timer_index} < LIMIT;
    assign addr     = r_item.timer_index[IDX_W-1:0];
    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;
    assign rd_en    = (r_state == S_SWEEP) && (r_rd_ptr != CNT_W'(TIMER_COUNT));

    ptb_mem #(.DEPTH(TIMER_COUNT), .ADDR_W(IDX_W), .WIDTH(PERIOD_W)) u_period_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (per_wr_en),
        .i_wr_addr (addr),
        .i_wr_data (per_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr[IDX_W-1:0]),
        .o_rd_data (per_rd_data)
    );

    ptb_mem #(.DEPTH(TIMER_COUNT), .ADDR_W(IDX_W), .WIDTH(PERIOD_W)) u_count_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (cnt_wr_en),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr[IDX_W-1:0]),
        .o_rd_data (cnt_rd_data)
    );

    ptb_update u_update (
        .i_count  (cnt_rd_data),
        .i_period (per_rd_data),
        .o_upd    (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_enable    <= '0;
            r_ready     <= '0;
            r_wb_vld    <= 1'b0;
            r_rd_ptr    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_enable    <= n_enable;
            r_ready     <= n_ready;
            r_wb_vld    <= rd_en;
            if (r_state == S_IDLE) begin
                r_rd_ptr <= '0;
            end else if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_wb_ptr   <= r_rd_ptr[IDX_W-1:0];
        if (accept) begin
            r_item <= i_in_item;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        n_enable    = r_enable;
        n_ready     = r_ready;
        o_in_stall  = 1'b1;
        per_wr_en   = 1'b0;
        per_wr_data = '0;
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = addr;
        cnt_wr_data = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = (i_in_item.action == ACT_TICK) ? S_SWEEP : S_POST;
                end
            end
            S_SWEEP: begin
                // write-back follows in the cycle after the read
                if (r_wb_vld && r_enable[r_wb_ptr]) begin
                    cnt_wr_en   = 1'b1;
                    cnt_wr_addr = r_wb_ptr;
                    cnt_wr_data = upd.count;
                    if (upd.fire) begin
                        n_ready[r_wb_ptr] = 1'b1;
                    end
                end
                if (r_wb_vld && r_wb_ptr == IDX_W'(TIMER_COUNT - 1)) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (out_free) begin
                    n_state                = S_IDLE;
                    n_out_valid            = 1'b1;
                    n_out_item.status      = STATUS_OK;
                    n_out_item.ready_out   = 1'b0;
                    n_out_item.enabled_out = 1'b0;
                    if (r_item.action != ACT_TICK && r_item.action <= ACT_READ_EN
                            && !in_range) begin
                        n_out_item.status = STATUS_ERR;
                    end else if (in_range) begin
                        priority case (r_item.action)
                            ACT_CONFIGURE: begin
                                per_wr_en   = 1'b1;
                                per_wr_data = r_item.period_ms;
                                cnt_wr_en   = 1'b1;
                            end
                            ACT_ENABLE:  n_enable[addr] = 1'b1;
                            ACT_DISABLE: n_enable[addr] = 1'b0;
                            ACT_TAKE: begin
                                n_out_item.ready_out = r_ready[addr];
                                if (r_ready[addr]) begin
                                    n_ready[addr] = 1'b0;
                                    cnt_wr_en     = 1'b1;
                                end
                            end
                            ACT_RESET_ONE: begin
                                per_wr_en      = 1'b1;
                                cnt_wr_en      = 1'b1;
                                n_enable[addr] = 1'b0;
                                n_ready[addr]  = 1'b0;
                            end
                            ACT_READ_EN: n_out_item.enabled_out = r_enable[addr];
                            default: ;
                        endcase
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_wb_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> r_state == S_SWEEP)
        else $error("count write-back outside the tick sweep");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_state != S_IDLE)
        else $error("accepted item did not start work");

    a_result_from_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_POST)
        else $error("result loaded outside the result state");

    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.status && (o_out_item.ready_out
            || o_out_item.enabled_out)))
        else $error("error status with a flag set");

endmodule
